>>> src/prp_pkg.sv
// shared constants, types and command codes of the page replacement core
package prp_pkg;

    // build-time sizes
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int AGE_W = IDX_W;

    // port field widths
    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 4;
    localparam int COUNT_W       = 32;
    localparam int MODE_W        = 2;
    localparam int FIU_W         = 5;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

    // replacement policy codes
    localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOCK = 2'd2;

    // commands broadcast to the frame cells
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_IDLE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOK = 3'd1;
    localparam logic [OP_W-1:0] OP_CLK  = 3'd2;
    localparam logic [OP_W-1:0] OP_MAX  = 3'd3;
    localparam logic [OP_W-1:0] OP_PICK = 3'd4;
    localparam logic [OP_W-1:0] OP_UPD  = 3'd5;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [AGE_W-1:0]     t_age;
    typedef logic [AGE_W:0]       t_rank;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [MODE_W-1:0]    t_mode;

    localparam t_age  AGE_MAX   = t_age'(FRAMES - 1);
    localparam t_rank RANK_NEW  = t_rank'(FRAMES);

    // command word seen by every cell
    typedef struct packed {
        t_op   op;
        t_page page;
        logic  first;
        t_age  bit_mask;
        logic  hit;
        t_mode mode;
        t_rank old_age;
        logic  clk_none;
        logic  wrap;
        t_idx  hand;
        t_idx  victim;
        t_cnt  n;
    } t_cmd;

    // where a cell stands relative to the count, hand and victim
    typedef struct packed {
        logic in_use;
        logic upper;
        logic before_v;
        logic is_v;
    } t_pos;

    // two priority chains passed from cell to cell
    typedef struct packed {
        logic a;
        logic b;
    } t_link;

    // search results of the row
    typedef struct packed {
        logic [FRAMES-1:0] sel_a;
        logic [FRAMES-1:0] sel_b;
        logic              any_a;
        logic              any_b;
        t_age              sel_age;
    } t_row_stat;

endpackage

>>> src/prp_cell.sv
// one page frame: tag, valid, lru rank, reference bit and priority chain stage
module prp_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prp_pkg::t_cmd i_cmd,
    input  prp_pkg::t_pos i_pos,
    input  prp_pkg::t_link i_link,
    input  logic          i_any_bit,
    output prp_pkg::t_link o_link,
    output prp_pkg::t_link o_sel,
    output logic          o_bit_hit,
    output prp_pkg::t_age o_age
);

    prp_pkg::t_page r_page;
    logic           r_valid, n_valid;
    prp_pkg::t_age  r_age, n_age;
    logic           r_ref, n_ref;
    logic           r_cand, n_cand;

    logic match, cand_clk, cand_eff, bit_now, passed, younger;
    logic flag_a, flag_b;

    // per-frame decisions
    always_comb begin
        match    = r_valid & i_pos.in_use & (r_page == i_cmd.page);
        cand_clk = i_pos.in_use & (~r_valid | ~r_ref);
        cand_eff = i_cmd.first ? i_pos.in_use : r_cand;
        bit_now  = cand_eff & (|(r_age & i_cmd.bit_mask));
        younger  = r_valid & i_pos.in_use & ({1'b0, r_age} < i_cmd.old_age);
        if (i_cmd.clk_none) begin
            passed = i_pos.in_use;
        end else if (i_cmd.wrap) begin
            passed = (i_pos.upper & i_pos.in_use) | i_pos.before_v;
        end else begin
            passed = i_pos.upper & i_pos.before_v;
        end

        n_valid = r_valid;
        n_age   = r_age;
        n_ref   = r_ref;
        n_cand  = r_cand;
        flag_a  = 1'b0;
        flag_b  = 1'b0;

        unique case (i_cmd.op)
            prp_pkg::OP_LOOK: begin
                flag_a = match;
                flag_b = i_pos.in_use & ~r_valid;
            end
            prp_pkg::OP_CLK: begin
                flag_a = cand_clk & i_pos.upper;
                flag_b = cand_clk;
            end
            prp_pkg::OP_MAX: begin
                // keep candidates that carry this age bit, if any does
                n_cand = cand_eff & (bit_now | ~i_any_bit);
            end
            prp_pkg::OP_PICK: begin
                flag_a = r_cand;
            end
            prp_pkg::OP_UPD: begin
                if (i_cmd.mode == prp_pkg::MODE_LRU) begin
                    if (i_pos.is_v) begin
                        n_age = '0;
                    end else if (younger && (r_age != prp_pkg::AGE_MAX)) begin
                        n_age = r_age + 1'b1;
                    end
                end
                if (i_cmd.mode == prp_pkg::MODE_CLOCK) begin
                    if (i_cmd.hit) begin
                        if (i_pos.is_v) n_ref = 1'b1;
                    end else if (passed) begin
                        n_ref = 1'b0;
                    end
                end
                if (!i_cmd.hit && i_pos.is_v) begin
                    n_valid = 1'b1;
                    n_ref   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
            r_ref   <= 1'b0;
            r_cand  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
            r_ref   <= n_ref;
            r_cand  <= n_cand;
        end
    end

    // page tag, only read while valid
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == prp_pkg::OP_UPD) && !i_cmd.hit && i_pos.is_v) begin
            r_page <= i_cmd.page;
        end
    end

    // priority chains: first flagged cell wins
    assign o_sel.a   = flag_a & ~i_link.a;
    assign o_sel.b   = flag_b & ~i_link.b;
    assign o_link.a  = i_link.a | flag_a;
    assign o_link.b  = i_link.b | flag_b;
    assign o_bit_hit = bit_now;
    assign o_age     = r_age;

endmodule

>>> src/prp_row.sv
// row of frame cells with their neighbor chains and the age bit reduction
module prp_row (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prp_pkg::t_cmd      i_cmd,
    output prp_pkg::t_row_stat o_stat
);

    prp_pkg::t_link               link [prp_pkg::FRAMES+1];
    prp_pkg::t_link               sel  [prp_pkg::FRAMES];
    logic [prp_pkg::FRAMES-1:0]   bit_hit;
    prp_pkg::t_age                age  [prp_pkg::FRAMES];
    logic                         any_bit;
    logic [prp_pkg::FRAMES-1:0]   sel_a;
    logic [prp_pkg::FRAMES-1:0]   sel_b;
    prp_pkg::t_age                sel_age;

    assign link[0] = '0;
    assign any_bit = |bit_hit;

    for (genvar i = 0; i < prp_pkg::FRAMES; i++) begin : g_cell
        prp_pkg::t_pos pos;

        // position of this frame against count, hand and victim
        assign pos.in_use   = (prp_pkg::t_cnt'(i) < i_cmd.n);
        assign pos.upper    = (prp_pkg::t_idx'(i) >= i_cmd.hand);
        assign pos.before_v = (prp_pkg::t_idx'(i) < i_cmd.victim);
        assign pos.is_v     = (prp_pkg::t_idx'(i) == i_cmd.victim);

        prp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (i_cmd),
            .i_pos     (pos),
            .i_link    (link[i]),
            .i_any_bit (any_bit),
            .o_link    (link[i+1]),
            .o_sel     (sel[i]),
            .o_bit_hit (bit_hit[i]),
            .o_age     (age[i])
        );

        assign sel_a[i] = sel[i].a;
        assign sel_b[i] = sel[i].b;
    end

    // rank of the frame picked on chain a
    always_comb begin
        sel_age = '0;
        for (int k = 0; k < prp_pkg::FRAMES; k++) begin
            if (sel[k].a) sel_age = sel_age | age[k];
        end
    end

    // search results of the row
    assign o_stat = {sel_a, sel_b, link[prp_pkg::FRAMES].a, link[prp_pkg::FRAMES].b, sel_age};

endmodule

>>> src/page_replacement_policy_core.sv
// page frame table with fifo, lru and second chance replacement: sequencer and counters
//
//   channel   direction  handshake             payload
//   request   in         i_valid / o_ready     i_page_number
//   result    out        o_valid / i_ready     o_hit o_frame_index o_request_count o_fault_count
//   config    in         i_cfg_wr_en           i_cfg_index i_cfg_wdata
//
// a hit, a fifo fault and an lru fault into an empty frame pass through accept,
// lookup, update and result; a second chance fault adds the clock search over the
// cell chain before the update; an lru fault with no empty frame adds one max-rank
// search step per age bit plus a pick step. one word is in flight at a time. reset
// clears the cells at once, no sweep. a result held by the output register does not
// block the next request; only the final load waits for i_ready.
module page_replacement_policy_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [prp_pkg::PAGE_NUMBER_W-1:0]     i_page_number,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic [prp_pkg::FRAME_INDEX_W-1:0]     o_frame_index,
    output logic [prp_pkg::COUNT_W-1:0]           o_request_count,
    output logic [prp_pkg::COUNT_W-1:0]           o_fault_count,
    input  logic                                  i_cfg_wr_en,
    input  logic [prp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [prp_pkg::FIU_W-1:0]             i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_CLK  = 3'd2;
    localparam logic [2:0] S_MAX  = 3'd3;
    localparam logic [2:0] S_PICK = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                   r_state, n_state;
    prp_pkg::t_mode               r_mode_cfg;
    logic [prp_pkg::FIU_W-1:0]    r_fin_cfg;
    prp_pkg::t_page               r_page, n_page;
    prp_pkg::t_mode               r_mode, n_mode;
    prp_pkg::t_cnt                r_n, n_n;
    prp_pkg::t_idx                r_fifo, n_fifo;
    prp_pkg::t_idx                r_hand, n_hand;
    logic [prp_pkg::COUNT_W-1:0]  r_req, n_req;
    logic [prp_pkg::COUNT_W-1:0]  r_flt, n_flt;
    logic                         r_hit, n_hit;
    prp_pkg::t_idx                r_v, n_v;
    prp_pkg::t_rank               r_old_age, n_old_age;
    logic                         r_clk_none, n_clk_none;
    logic                         r_wrap, n_wrap;
    prp_pkg::t_age                r_bit, n_bit;
    logic                         r_first, n_first;
    logic                         r_o_valid, n_o_valid;
    logic                         r_o_hit, n_o_hit;
    prp_pkg::t_idx                r_o_idx, n_o_idx;
    logic [prp_pkg::COUNT_W-1:0]  r_o_req, n_o_req;
    logic [prp_pkg::COUNT_W-1:0]  r_o_flt, n_o_flt;

    prp_pkg::t_cmd                cmd;
    prp_pkg::t_row_stat           stat;
    prp_pkg::t_cnt                cnt_norm;
    logic                         accept;

    // next frame after v, wrapping at the active count
    function automatic prp_pkg::t_idx wrap_next(prp_pkg::t_idx v, prp_pkg::t_cnt n);
        logic [prp_pkg::CNT_W:0] s;
        s = (prp_pkg::CNT_W + 1)'(v) + 1'b1;
        return (s >= {1'b0, n}) ? '0 : prp_pkg::t_idx'(s);
    endfunction

    // one-hot select to frame number
    function automatic prp_pkg::t_idx onehot_idx(logic [prp_pkg::FRAMES-1:0] sel);
        prp_pkg::t_idx r;
        r = '0;
        for (int k = 0; k < prp_pkg::FRAMES; k++) begin
            if (sel[k]) r = r | prp_pkg::t_idx'(k);
        end
        return r;
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid & o_ready;

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        if (r_fin_cfg == '0) begin
            cnt_norm = prp_pkg::t_cnt'(1);
        end else if (32'(r_fin_cfg) > prp_pkg::FRAMES) begin
            cnt_norm = prp_pkg::t_cnt'(prp_pkg::FRAMES);
        end else begin
            cnt_norm = prp_pkg::t_cnt'(r_fin_cfg);
        end
    end

    // command broadcast to the cells
    always_comb begin
        cmd.page     = r_page;
        cmd.first    = r_first;
        cmd.bit_mask = r_bit;
        cmd.hit      = r_hit;
        cmd.mode     = r_mode;
        cmd.old_age  = r_old_age;
        cmd.clk_none = r_clk_none;
        cmd.wrap     = r_wrap;
        cmd.hand     = r_hand;
        cmd.victim   = r_v;
        cmd.n        = r_n;
        unique case (r_state)
            S_LOOK:  cmd.op = prp_pkg::OP_LOOK;
            S_CLK:   cmd.op = prp_pkg::OP_CLK;
            S_MAX:   cmd.op = prp_pkg::OP_MAX;
            S_PICK:  cmd.op = prp_pkg::OP_PICK;
            S_UPD:   cmd.op = prp_pkg::OP_UPD;
            default: cmd.op = prp_pkg::OP_IDLE;
        endcase
    end

    prp_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_page     = r_page;
        n_mode     = r_mode;
        n_n        = r_n;
        n_fifo     = r_fifo;
        n_hand     = r_hand;
        n_req      = r_req;
        n_flt      = r_flt;
        n_hit      = r_hit;
        n_v        = r_v;
        n_old_age  = r_old_age;
        n_clk_none = r_clk_none;
        n_wrap     = r_wrap;
        n_bit      = r_bit;
        n_first    = r_first;
        n_o_valid  = r_o_valid & ~i_ready;
        n_o_hit    = r_o_hit;
        n_o_idx    = r_o_idx;
        n_o_req    = r_o_req;
        n_o_flt    = r_o_flt;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_page = prp_pkg::t_page'(i_page_number);
                    case (r_mode_cfg)
                        prp_pkg::MODE_LRU:   n_mode = prp_pkg::MODE_LRU;
                        prp_pkg::MODE_CLOCK: n_mode = prp_pkg::MODE_CLOCK;
                        default:             n_mode = prp_pkg::MODE_FIFO;
                    endcase
                    n_n = cnt_norm;
                    // pointers left beyond a shrunk count restart at frame 0
                    n_fifo = (prp_pkg::t_cnt'(r_fifo) >= cnt_norm) ? '0 : r_fifo;
                    n_hand = (prp_pkg::t_cnt'(r_hand) >= cnt_norm) ? '0 : r_hand;
                    if (r_req != '1) n_req = r_req + 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (stat.any_a) begin
                    n_hit     = 1'b1;
                    n_v       = onehot_idx(stat.sel_a);
                    n_old_age = {1'b0, stat.sel_age};
                    n_state   = S_UPD;
                end else begin
                    n_hit     = 1'b0;
                    n_old_age = prp_pkg::RANK_NEW;
                    if (r_flt != '1) n_flt = r_flt + 1'b1;
                    case (r_mode)
                        prp_pkg::MODE_LRU: begin
                            if (stat.any_b) begin
                                n_v     = onehot_idx(stat.sel_b);
                                n_state = S_UPD;
                            end else begin
                                n_bit   = prp_pkg::t_age'(1) << (prp_pkg::AGE_W - 1);
                                n_first = 1'b1;
                                n_state = S_MAX;
                            end
                        end
                        prp_pkg::MODE_CLOCK: begin
                            n_state = S_CLK;
                        end
                        default: begin
                            n_v     = r_fifo;
                            n_fifo  = wrap_next(r_fifo, r_n);
                            n_state = S_UPD;
                        end
                    endcase
                end
            end
            S_CLK: begin
                // first unreferenced frame from the hand, wrapping once
                if (stat.any_a) begin
                    n_v = onehot_idx(stat.sel_a);
                end else if (stat.any_b) begin
                    n_v = onehot_idx(stat.sel_b);
                end else begin
                    n_v = r_hand;
                end
                n_clk_none = ~stat.any_b;
                n_wrap     = ~stat.any_a & stat.any_b;
                n_state    = S_UPD;
            end
            S_MAX: begin
                n_first = 1'b0;
                n_bit   = r_bit >> 1;
                if (r_bit[0]) n_state = S_PICK;
            end
            S_PICK: begin
                n_v     = onehot_idx(stat.sel_a);
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_hit && (r_mode == prp_pkg::MODE_CLOCK)) begin
                    n_hand = wrap_next(r_v, r_n);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_hit;
                    n_o_idx   = r_v;
                    n_o_req   = r_req;
                    n_o_flt   = r_flt;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode_cfg <= prp_pkg::MODE_FIFO;
            r_fin_cfg  <= prp_pkg::FIU_W'(prp_pkg::FRAMES);
            r_mode     <= prp_pkg::MODE_FIFO;
            r_n        <= prp_pkg::t_cnt'(prp_pkg::FRAMES);
            r_fifo     <= '0;
            r_hand     <= '0;
            r_req      <= '0;
            r_flt      <= '0;
            r_hit      <= 1'b0;
            r_v        <= '0;
            r_clk_none <= 1'b0;
            r_wrap     <= 1'b0;
            r_bit      <= '0;
            r_first    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_n        <= n_n;
            r_fifo     <= n_fifo;
            r_hand     <= n_hand;
            r_req      <= n_req;
            r_flt      <= n_flt;
            r_hit      <= n_hit;
            r_v        <= n_v;
            r_clk_none <= n_clk_none;
            r_wrap     <= n_wrap;
            r_bit      <= n_bit;
            r_first    <= n_first;
            r_o_valid  <= n_o_valid;
            // configuration writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    prp_pkg::CFG_POLICY_MODE:   r_mode_cfg <= i_cfg_wdata[prp_pkg::MODE_W-1:0];
                    prp_pkg::CFG_FRAMES_IN_USE: r_fin_cfg  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_old_age <= n_old_age;
        r_o_hit   <= n_o_hit;
        r_o_idx   <= n_o_idx;
        r_o_req   <= n_o_req;
        r_o_flt   <= n_o_flt;
    end

    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = prp_pkg::FRAME_INDEX_W'(r_o_idx);
    assign o_request_count = r_o_req;
    assign o_fault_count   = r_o_flt;

`ifndef SYNTHESIS
    // faults never outnumber requests
    a_flt_le_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flt <= r_req)
        else $error("fault count above request count");

    // the victim or hit frame is always an active frame
    a_victim_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (prp_pkg::t_cnt'(r_v) < r_n))
        else $error("selected frame beyond active count");

    // at most one frame matches after the priority chain
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $onehot0(stat.sel_a))
        else $error("more than one frame selected");

    // an accepted request starts a lookup
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted request did not start lookup");

    // a finished result waits while the output register is still taken
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_o_valid && !i_ready |=> (r_state == S_DONE))
        else $error("result overwrote a pending output word");
`endif

endmodule
